@@ hdl/rht_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package rht_pkg;

  localparam int ENTRIES_DEF = 8;

  localparam logic [1:0] KIND_ALLOC   = 2'd0;
  localparam logic [1:0] KIND_DUP     = 2'd1;
  localparam logic [1:0] KIND_RELEASE = 2'd2;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_NOFREE  = 3'd1;
  localparam logic [2:0] ST_NOTUSED = 3'd2;
  localparam logic [2:0] ST_UNDER   = 3'd3;
  localparam logic [2:0] ST_OVER    = 3'd4;

  localparam logic [7:0] COUNT_MAX = 8'hFF;

  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] entry_index;
    logic [7:0] open_mode;
    logic [7:0] inode_id;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [2:0] result_index;
    logic [7:0] ref_count;
    logic       freed;
    logic [7:0] inode_to_put;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic accept;  // latch request, launch reads
    logic commit;  // update tables, load result word
  } cmd_t;

endpackage

`default_nettype wire

@@ hdl/refcounted_handle_table.sv @@
`timescale 1ns / 1ps
`default_nettype none

// channel | valid      | stall       | word
// --------+------------+-------------+-------------------------
// request | in_valid_i | in_stall_o  | in_data_i  (req_t)
// result  | out_valid_o| out_stall_i | out_data_o (rsp_t)
//
// Per request: the accept edge launches the table reads, and a later commit edge
// updates the tables and loads the result register.
// A new request is taken while the previous result still waits; its update
// holds until the result register is free.
// After reset the free stack is full and every entry is unused; no clearing pass.

module refcounted_handle_table #(
  parameter int ENTRIES = rht_pkg::ENTRIES_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire rht_pkg::req_t in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output rht_pkg::rsp_t      out_data_o
);

  rht_pkg::cmd_t cmd;

  rht_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  rht_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_data_i  (in_data_i),
    .out_data_o (out_data_o)
  );

endmodule

`default_nettype wire

@@ hdl/rht_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rht_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output rht_pkg::cmd_t      cmd_o
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic slot_free;

  assign slot_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o.accept = (state_q == S_IDLE) && in_valid_i;
    cmd_o.commit = (state_q == S_EXEC) && slot_free;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (slot_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

@@ hdl/rht_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rht_dp #(
  parameter int ENTRIES = rht_pkg::ENTRIES_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire rht_pkg::cmd_t cmd_i,
  input  wire rht_pkg::req_t in_data_i,
  output rht_pkg::rsp_t      out_data_o
);

  localparam int IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int TopW = $clog2(ENTRIES + 1);

  // tables
  logic [IdxW-1:0] stk_mem [ENTRIES];
  logic [7:0]      cnt_mem [ENTRIES];
  logic [7:0]      ino_mem [ENTRIES];

  logic [ENTRIES-1:0] stk_vld_q;  // unwritten stack slot reads as its own index
  logic [ENTRIES-1:0] in_use_q;
  logic [TopW-1:0]    top_q, top_d;

  rht_pkg::req_t   req_q;
  rht_pkg::rsp_t   rsp_q, rsp_d;
  logic [IdxW-1:0] stk_rd_q;
  logic [7:0]      cnt_rd_q;
  logic [7:0]      ino_rd_q;

  logic [IdxW-1:0] rd_idx;
  logic [IdxW-1:0] ie;
  logic [IdxW-1:0] pop_addr;
  logic [IdxW-1:0] push_addr;
  logic [IdxW-1:0] pop_entry;
  logic            idx_ok;
  logic [7:0]      cnt_dec;

  logic            cnt_we;
  logic [IdxW-1:0] cnt_wa;
  logic [7:0]      cnt_wd;
  logic            ino_we;
  logic            stk_we;
  logic            use_set;
  logic            use_clr;
  logic [IdxW-1:0] use_a;

  assign rd_idx    = IdxW'(in_data_i.entry_index);
  assign ie        = IdxW'(req_q.entry_index);
  assign idx_ok    = int'(req_q.entry_index) < ENTRIES;
  assign pop_addr  = (top_q == '0) ? '0 : IdxW'(top_q - TopW'(1));
  assign push_addr = IdxW'(top_q);
  assign pop_entry = stk_vld_q[pop_addr] ? stk_rd_q : pop_addr;
  assign cnt_dec   = cnt_rd_q - 8'd1;

  always_comb begin
    rsp_d   = '0;
    top_d   = top_q;
    cnt_we  = 1'b0;
    cnt_wa  = ie;
    cnt_wd  = '0;
    ino_we  = 1'b0;
    stk_we  = 1'b0;
    use_set = 1'b0;
    use_clr = 1'b0;
    use_a   = ie;
    case (req_q.kind)
      rht_pkg::KIND_ALLOC: begin
        if (top_q == '0) begin
          rsp_d.status = rht_pkg::ST_NOFREE;
        end else begin
          top_d              = top_q - TopW'(1);
          use_set            = 1'b1;
          use_a              = pop_entry;
          cnt_we             = 1'b1;
          cnt_wa             = pop_entry;
          ino_we             = 1'b1;
          rsp_d.status       = rht_pkg::ST_OK;
          rsp_d.result_index = 3'(pop_entry);
        end
      end
      rht_pkg::KIND_DUP, rht_pkg::KIND_RELEASE: begin
        rsp_d.result_index = req_q.entry_index;
        if (!idx_ok || !in_use_q[ie]) begin
          rsp_d.status = rht_pkg::ST_NOTUSED;
        end else if (req_q.kind == rht_pkg::KIND_DUP) begin
          if (cnt_rd_q == rht_pkg::COUNT_MAX) begin
            rsp_d.status    = rht_pkg::ST_OVER;
            rsp_d.ref_count = rht_pkg::COUNT_MAX;
          end else begin
            cnt_we          = 1'b1;
            cnt_wd          = cnt_rd_q + 8'd1;
            rsp_d.status    = rht_pkg::ST_OK;
            rsp_d.ref_count = cnt_rd_q + 8'd1;
          end
        end else if (cnt_rd_q == '0) begin
          rsp_d.status = rht_pkg::ST_UNDER;
        end else begin
          cnt_we          = 1'b1;
          cnt_wd          = cnt_dec;
          rsp_d.status    = rht_pkg::ST_OK;
          rsp_d.ref_count = cnt_dec;
          if (cnt_dec == '0) begin
            use_clr            = 1'b1;
            rsp_d.freed        = 1'b1;
            rsp_d.inode_to_put = ino_rd_q;
            if (int'(top_q) < ENTRIES) begin
              stk_we = 1'b1;
              top_d  = top_q + TopW'(1);
            end
          end
        end
      end
      default: begin
        rsp_d.status       = rht_pkg::ST_NOTUSED;
        rsp_d.result_index = req_q.entry_index;
      end
    endcase
  end

  // request word and registered table reads
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      req_q    <= in_data_i;
      stk_rd_q <= stk_mem[pop_addr];
      cnt_rd_q <= cnt_mem[rd_idx];
      ino_rd_q <= ino_mem[rd_idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      rsp_q <= rsp_d;
      if (cnt_we) begin
        cnt_mem[cnt_wa] <= cnt_wd;
      end
      if (ino_we) begin
        ino_mem[pop_entry] <= req_q.inode_id;
      end
      if (stk_we) begin
        stk_mem[push_addr] <= ie;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q     <= TopW'(ENTRIES);
      stk_vld_q <= '0;
      in_use_q  <= '0;
    end else if (cmd_i.commit) begin
      top_q <= top_d;
      if (stk_we) begin
        stk_vld_q[push_addr] <= 1'b1;
      end
      if (use_set) begin
        in_use_q[use_a] <= 1'b1;
      end else if (use_clr) begin
        in_use_q[use_a] <= 1'b0;
      end
    end
  end

  assign out_data_o = rsp_q;

endmodule

`default_nettype wire
